/* hw/rtl/mexp_pkg.sv */
`default_nettype none
package mexp_pkg;

	localparam int WIDTH    = 32;
	localparam int EXP_BITS = 32;

	// multiplier step counter, holds WIDTH itself
	localparam int MCNT_W = $clog2(WIDTH + 1);

	typedef logic [WIDTH-1:0]    word_t;
	typedef logic [EXP_BITS-1:0] exp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_RED_W,
		ST_SCAN,
		ST_MUL,
		ST_MUL_W,
		ST_SQR,
		ST_SQR_W,
		ST_FIN
	} state_t;

endpackage
`default_nettype wire

/* hw/rtl/mexp_cmd_if.sv */
`default_nettype none
interface mexp_cmd_if;
	import mexp_pkg::*;

	logic  valid;
	logic  ready;
	word_t base;
	exp_t  exponent;
	word_t modulus;

	modport source (output valid, output base, output exponent, output modulus, input ready);
	modport sink (input valid, input base, input exponent, input modulus, output ready);

endinterface
`default_nettype wire

/* hw/rtl/mexp_rsp_if.sv */
`default_nettype none
interface mexp_rsp_if;
	import mexp_pkg::*;

	logic  valid;
	logic  ready;
	word_t result;

	modport source (output valid, output result, input ready);
	modport sink (input valid, input result, output ready);

endinterface
`default_nettype wire

/* hw/rtl/mexp_mulmod.sv */
`default_nettype none
module mexp_mulmod (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mexp_pkg::word_t x,
	input  mexp_pkg::word_t y,
	input  mexp_pkg::word_t m,
	output mexp_pkg::word_t p,
	output logic            done
);
	import mexp_pkg::*;

	// 2*acc + x stays below 3*m
	localparam int TW = WIDTH + 2;

	word_t             acc_q;
	word_t             y_q;
	logic [MCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TW-1:0] t;
	logic [TW:0]   d1;
	logic [TW:0]   d2;
	word_t         nxt;

	// one double-and-add step, multiplier bits taken msb first
	always_comb begin
		t  = {1'b0, acc_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x} : {TW{1'b0}});
		d1 = {1'b0, t} - {3'b000, m};
		d2 = {1'b0, t} - {2'b00, m, 1'b0};
		if (!d2[TW]) begin
			nxt = d2[WIDTH-1:0];
		end else if (!d1[TW]) begin
			nxt = d1[WIDTH-1:0];
		end else begin
			nxt = t[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= MCNT_W'(WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - MCNT_W'(1);
			if (cnt_q == MCNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			y_q   <= y;
		end else if (busy_q) begin
			acc_q <= nxt;
			y_q   <= {y_q[WIDTH-2:0], 1'b0};
		end
	end

	assign p    = acc_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/modular_exponentiation.sv */
// run time: grows with the exponent; the bit scan stops once the remaining exponent bits are all zero
// a set exponent bit costs a multiply and a square, a clear one only a square
// throughput: one item at a time; every modular product runs through the bit-serial multiplier
// the next item is taken while a finished result still waits in the output register
// reset: asynchronous, active low; returns to idle with no result pending, no clearing pass
`default_nettype none
module modular_exponentiation (
	input  logic       clk,
	input  logic       arst_n,
	mexp_cmd_if.sink   cmd,
	mexp_rsp_if.source rsp
);
	import mexp_pkg::*;

	state_t state_q;
	state_t state_d;

	word_t base_q;
	word_t mod_q;
	word_t acc_q;
	word_t sq_q;
	word_t res_q;
	exp_t  exp_q;
	logic  rsp_valid_q;

	logic  accept;
	logic  load_out;
	logic  mul_start;
	word_t mul_x;
	word_t mul_y;
	word_t mul_p;
	logic  mul_done;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_RED;
			end
			ST_RED: begin
				state_d = (mod_q == '0) ? ST_FIN : ST_RED_W;
			end
			ST_RED_W: begin
				if (mul_done) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (exp_q == '0) begin
					state_d = ST_FIN;
				end else if (exp_q[0]) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL: begin
				state_d = ST_MUL_W;
			end
			ST_MUL_W: begin
				if (mul_done) state_d = ST_SQR;
			end
			ST_SQR: begin
				state_d = ST_SQR_W;
			end
			ST_SQR_W: begin
				if (mul_done) state_d = ST_SCAN;
			end
			ST_FIN: begin
				if (!rsp_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// base reduction runs as (1 mod m) * base through the same multiplier
	always_comb begin
		mul_start = ((state_q == ST_RED) && (mod_q != '0)) ||
		            (state_q == ST_MUL) || (state_q == ST_SQR);
		mul_x     = (state_q inside {ST_SQR, ST_SQR_W}) ? sq_q : acc_q;
		mul_y     = (state_q == ST_RED) ? base_q : sq_q;
		load_out  = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);
	end

	mexp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.m      (mod_q),
		.p      (mul_p),
		.done   (mul_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= cmd.base;
			exp_q  <= cmd.exponent;
			mod_q  <= cmd.modulus;
			// 1 mod m, zero for a modulus of one or zero
			acc_q  <= (cmd.modulus <= word_t'(1)) ? '0 : word_t'(1);
		end else if (mul_done && (state_q == ST_MUL_W)) begin
			acc_q <= mul_p;
		end
		if (mul_done && ((state_q == ST_RED_W) || (state_q == ST_SQR_W))) begin
			sq_q <= mul_p;
		end
		if (mul_done && (state_q == ST_SQR_W)) begin
			exp_q <= exp_q >> 1;
		end
		if (load_out) begin
			res_q <= acc_q;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.result = res_q;

endmodule
`default_nettype wire

/* hw/rtl/mexp_check.sv */
`default_nettype none
module mexp_check (
	input logic            clk,
	input logic            arst_n,
	input logic            cmd_valid,
	input logic            cmd_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input mexp_pkg::word_t rsp_result
);
	import mexp_pkg::*;

	// items taken and not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(cmd_valid && cmd_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_result))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without an item");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == 2'd2) || ((pend_q == 2'd1) && !rsp_valid) |-> !cmd_ready)
		else $error("item taken while another is in work");

endmodule

bind modular_exponentiation mexp_check u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_result (rsp.result)
);
`default_nettype wire

/* test/modular_exponentiation_test.sv */
`timescale 1ns / 1ps
module modular_exponentiation_test;
	import mexp_pkg::*;

	typedef struct {
		word_t base;
		exp_t  exponent;
		word_t modulus;
	} job_t;

	typedef struct {
		job_t  job;
		word_t result;
	} answer_t;

	logic clk;
	logic arst_n;

	mexp_cmd_if cmd_bus ();
	mexp_rsp_if rsp_bus ();

	modular_exponentiation dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_bus),
		.rsp   (rsp_bus)
	);

	job_t    job_q[$];
	answer_t answer_q[$];
	job_t    next_job;
	answer_t due;
	int      errors;
	int      sent;
	int      received;
	int      send_idle;
	int      recv_idle;
	int      hold_left;
	bit      hold_done;

	// square-and-multiply over the exponent bits, products kept at double width
	function automatic word_t pow_mod(word_t b, exp_t e, word_t m);
		logic [2*WIDTH-1:0] sq;
		logic [2*WIDTH-1:0] acc;
		logic [2*WIDTH-1:0] mw;
		if (m == '0)
			return '0;
		mw  = {{WIDTH{1'b0}}, m};
		sq  = {{WIDTH{1'b0}}, b} % mw;
		acc = 1 % mw;
		for (int i = 0; i < EXP_BITS; i++) begin
			if (e[i])
				acc = (acc * sq) % mw;
			sq = (sq * sq) % mw;
		end
		return acc[WIDTH-1:0];
	endfunction

	// mostly no gap, often a short one, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(12, 60);
	endfunction

	task automatic flag_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic add_job(word_t b, exp_t e, word_t m);
		job_t j;
		j.base     = b;
		j.exponent = e;
		j.modulus  = m;
		job_q.push_back(j);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// command side: hold the item until taken, then maybe pause
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid    <= 1'b0;
			cmd_bus.base     <= '0;
			cmd_bus.exponent <= '0;
			cmd_bus.modulus  <= '0;
			send_idle        <= 0;
			sent             <= 0;
		end else if (!cmd_bus.valid || cmd_bus.ready) begin
			if (send_idle > 0) begin
				cmd_bus.valid <= 1'b0;
				send_idle     <= send_idle - 1;
			end else if (job_q.size() > 0) begin
				next_job = job_q.pop_front();
				answer_q.push_back('{next_job, pow_mod(next_job.base, next_job.exponent,
					next_job.modulus)});
				cmd_bus.valid    <= 1'b1;
				cmd_bus.base     <= next_job.base;
				cmd_bus.exponent <= next_job.exponent;
				cmd_bus.modulus  <= next_job.modulus;
				sent             <= sent + 1;
				// every fourth stretch of items goes without pauses
				send_idle        <= ((sent / 40) % 4 == 2) ? 0 : idle_len();
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// result side: check each item taken, then decide ready for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			recv_idle     <= 0;
			received      <= 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				received <= received + 1;
				if (answer_q.size() == 0) begin
					flag_mismatch($sformatf("result %h with nothing outstanding",
						rsp_bus.result));
				end else begin
					due = answer_q.pop_front();
					if (rsp_bus.result !== due.result)
						flag_mismatch($sformatf("%h ^ %h mod %h: got %h, want %h",
							due.job.base, due.job.exponent, due.job.modulus,
							rsp_bus.result, due.result));
				end
			end
			if (hold_left > 0) begin
				rsp_bus.ready <= 1'b0;
			end else if (recv_idle > 0) begin
				rsp_bus.ready <= 1'b0;
				recv_idle     <= recv_idle - 1;
			end else begin
				rsp_bus.ready <= 1'b1;
				recv_idle     <= ((received / 50) % 3 == 1) ? 0 : idle_len();
			end
		end
	end

	// one long back-pressure window, long enough for the block to fill and block its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && received == 30) begin
			hold_left <= 6000;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		word_t b;
		exp_t  e;
		word_t m;
		int    r;

		errors           = 0;
		arst_n           = 1'b0;
		cmd_bus.valid    = 1'b0;
		cmd_bus.base     = '0;
		cmd_bus.exponent = '0;
		cmd_bus.modulus  = '0;
		rsp_bus.ready    = 1'b0;

		// zero exponent, modulus of one, and the field extremes
		add_job('0, '0, 1);
		add_job('1, '1, 1);
		add_job('0, '0, '1);
		add_job(5, '0, '1);
		add_job('0, '0, 13);
		add_job('0, 7, 13);
		add_job('1, 1, '1);
		add_job('1, '1, '1);
		add_job('1, '1, 32'hFFFF_FFFE);
		add_job(1, '1, '1);
		// fermat check against the largest 32-bit prime
		add_job(2, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
		add_job(123456789, 1, 1000);
		add_job(32'hDEAD_BEEF, 2, 2);
		add_job(3, 32'h8000_0000, 32'h8000_0000);
		add_job(32'h8000_0000, 2, 32'h7FFF_FFFF);
		add_job(7, 13, 32'h8000_0001);
		add_job(2, 31, '1);
		add_job(2, 32, '1);
		add_job(32'hFFFF_FFFE, 2, '1);
		add_job(3, 200, 2);
		add_job(10, 3, 1000);

		for (int n = 0; n < 270; n++) begin
			r = $urandom_range(0, 19);
			if (r < 3)
				b = $urandom_range(0, 3);
			else if (r == 3)
				b = '1;
			else
				b = $urandom;

			r = $urandom_range(0, 19);
			if (r < 2) begin
				m = 1;
			end else if (r < 4) begin
				m = $urandom_range(2, 16);
			end else if (r == 4) begin
				m = '1;
			end else begin
				m = $urandom;
				if (m == '0)
					m = 1;
			end

			// short exponents keep most items cheap, a few run every bit set
			r = $urandom_range(0, 19);
			if (r < 12)
				e = $urandom >> $urandom_range(8, 31);
			else if (r < 18)
				e = $urandom;
			else if (r == 18)
				e = '0;
			else
				e = '1;

			add_job(b, e, m);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (job_q.size() > 0 || cmd_bus.valid)
			@(posedge clk);
		while (answer_q.size() > 0)
			@(posedge clk);
		// any stray extra result would show up within one item time
		repeat (2300) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* modular_exponentiation.f */
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_cmd_if.sv
hw/rtl/mexp_rsp_if.sv
hw/rtl/mexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
hw/rtl/mexp_check.sv
test/modular_exponentiation_test.sv
